// ===== hdl/modbus_rtu_frame_receiver_top_macros.svh =====
// assertion macros used by the checker file of the frame receiver
`ifndef MODBUS_RTU_FRAME_RECEIVER_TOP_MACROS_SVH
`define MODBUS_RTU_FRAME_RECEIVER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define MRFR_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frame receiver assertion failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define MRFR_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frame receiver assertion failed");

`endif

// ===== hdl/mrfr_pkg.sv =====
// shared types, codes and the crc-16/modbus byte step of the frame receiver
`timescale 1ns / 1ps

package mrfr_pkg;

	localparam int BUFFER_DEPTH_DEF = 256;
	localparam logic [15:0] TIMEOUT_RESET = 16'd5;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] SILENCE_MAX = 16'hFFFF;
	localparam logic [8:0] MIN_FRAME_LEN = 9'd3;

	typedef enum logic [1:0] {
		ACT_BYTE  = 2'd0,
		ACT_TICK  = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_READ  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		EV_NONE     = 2'd0,
		EV_GOOD     = 2'd1,
		EV_CRC_FAIL = 2'd2
	} event_t;

	// memory access strobes from the control path to the frame store
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} store_ctl_t;

	// fold one byte into the reflected crc, one bit per step
	function automatic logic [15:0] crc_absorb(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== hdl/mrfr_store.sv =====
// frame byte store: one write port, one read port with registered data
`timescale 1ns / 1ps

module mrfr_store #(
	parameter int BUFFER_DEPTH = mrfr_pkg::BUFFER_DEPTH_DEF,
	localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
	input  logic                 clk,
	input  mrfr_pkg::store_ctl_t store_ctl,
	input  logic [AW-1:0]        wr_addr,
	input  logic [7:0]           wr_data,
	input  logic [AW-1:0]        rd_addr,
	output logic [7:0]           rd_data
);

	logic [7:0] mem_q [BUFFER_DEPTH];
	logic [7:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (store_ctl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (store_ctl.rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/mrfr_ctrl.sv =====
// frame state, crc, silence timing and the result register of the receiver
`timescale 1ns / 1ps

module mrfr_ctrl #(
	parameter int BUFFER_DEPTH = mrfr_pkg::BUFFER_DEPTH_DEF,
	localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [15:0]          cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           action,
	input  logic [7:0]           data_byte,
	input  logic [7:0]           read_index,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           frame_event,
	output logic                 frame_held,
	output logic [8:0]           frame_length,
	output logic [7:0]           read_data,
	output mrfr_pkg::store_ctl_t store_ctl,
	output logic [AW-1:0]        wr_addr,
	output logic [7:0]           wr_data,
	output logic [AW-1:0]        rd_addr,
	input  logic [7:0]           rd_data
);

	localparam logic [8:0] DEPTH = 9'(BUFFER_DEPTH);

	logic [15:0]      timeout_q;
	logic [8:0]       fill_q;
	logic             ready_q;
	logic [15:0]      silence_q;
	logic [15:0]      crc_q;
	logic             out_valid_s1;
	mrfr_pkg::event_t event_s1;
	logic             rd_sel_s1;

	logic             accept;
	logic [8:0]       fill_nxt;
	logic             ready_nxt;
	logic [15:0]      silence_nxt;
	logic [15:0]      crc_nxt;
	mrfr_pkg::event_t event_nxt;
	logic             rd_sel_nxt;
	logic [15:0]      silence_inc;

	// result register frees or drains in the same cycle
	assign in_ready = !out_valid_s1 || out_ready;
	assign accept = in_valid && in_ready;

	assign silence_inc = (silence_q == mrfr_pkg::SILENCE_MAX) ? silence_q : silence_q + 16'd1;

	// next frame state for the incoming transaction
	always_comb begin
		fill_nxt = fill_q;
		ready_nxt = ready_q;
		silence_nxt = silence_q;
		crc_nxt = crc_q;
		event_nxt = mrfr_pkg::EV_NONE;
		rd_sel_nxt = 1'b0;
		store_ctl = '0;
		case (mrfr_pkg::action_t'(action))
			mrfr_pkg::ACT_BYTE: begin
				if (fill_q >= DEPTH) begin
					// overflow drops the frame and the byte
					fill_nxt = '0;
					ready_nxt = 1'b0;
					crc_nxt = mrfr_pkg::CRC_INIT;
				end else begin
					store_ctl.wr_en = accept;
					fill_nxt = fill_q + 9'd1;
					crc_nxt = mrfr_pkg::crc_absorb(crc_q, data_byte);
					silence_nxt = '0;
				end
			end
			mrfr_pkg::ACT_TICK: begin
				silence_nxt = silence_inc;
				if (fill_q != '0 && !ready_q && silence_inc >= timeout_q) begin
					if (fill_q >= mrfr_pkg::MIN_FRAME_LEN && crc_q == '0) begin
						ready_nxt = 1'b1;
						event_nxt = mrfr_pkg::EV_GOOD;
					end else begin
						fill_nxt = '0;
						ready_nxt = 1'b0;
						crc_nxt = mrfr_pkg::CRC_INIT;
						event_nxt = mrfr_pkg::EV_CRC_FAIL;
					end
				end
			end
			mrfr_pkg::ACT_CLEAR: begin
				fill_nxt = '0;
				ready_nxt = 1'b0;
				crc_nxt = mrfr_pkg::CRC_INIT;
			end
			mrfr_pkg::ACT_READ: begin
				if ({1'b0, read_index} < DEPTH) begin
					rd_sel_nxt = 1'b1;
					store_ctl.rd_en = accept;
				end
			end
			default: begin
				fill_nxt = fill_q;
			end
		endcase
	end

	assign wr_addr = fill_q[AW-1:0];
	assign wr_data = data_byte;
	assign rd_addr = read_index[AW-1:0];

	// timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= mrfr_pkg::TIMEOUT_RESET;
		end else if (cfg_wr_en) begin
			timeout_q <= cfg_wr_data;
		end
	end

	// frame state and result register move together on a transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			ready_q <= 1'b0;
			silence_q <= '0;
			crc_q <= mrfr_pkg::CRC_INIT;
			out_valid_s1 <= 1'b0;
			event_s1 <= mrfr_pkg::EV_NONE;
			rd_sel_s1 <= 1'b0;
		end else begin
			if (accept) begin
				fill_q <= fill_nxt;
				ready_q <= ready_nxt;
				silence_q <= silence_nxt;
				crc_q <= crc_nxt;
				event_s1 <= event_nxt;
				rd_sel_s1 <= rd_sel_nxt;
				out_valid_s1 <= 1'b1;
			end else if (out_ready) begin
				out_valid_s1 <= 1'b0;
			end
		end
	end

	// results; ready and length are the state just loaded
	assign out_valid = out_valid_s1;
	assign frame_event = event_s1;
	assign frame_held = ready_q;
	assign frame_length = fill_q;
	assign read_data = rd_sel_s1 ? rd_data : 8'h00;

endmodule

// ===== hdl/modbus_rtu_frame_receiver_top.sv =====
// modbus rtu frame receiver with running crc-16/modbus check
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------------------
//  input    | in_valid / in_ready   | action, data_byte, read_index
//  result   | out_valid / out_ready | frame_event, frame_held, frame_length, read_data
//  config   | cfg_wr_en             | cfg_wr_data (timeout_ticks)
//
// one transaction per cycle while in_ready is high; each result appears in the cycle after its transaction
// the frame store read is synchronous and is registered at the same edge as the result
// in_ready drops only while a result waits and out_ready is low
// reset clears length, ready flag and silence, loads crc 0xFFFF and timeout 5
// store contents are not cleared; stale bytes remain readable
`timescale 1ns / 1ps

module modbus_rtu_frame_receiver_top #(
	parameter int BUFFER_DEPTH = mrfr_pkg::BUFFER_DEPTH_DEF,
	localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [7:0]  data_byte,
	input  logic [7:0]  read_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  frame_event,
	output logic        frame_held,
	output logic [8:0]  frame_length,
	output logic [7:0]  read_data
);

	mrfr_pkg::store_ctl_t store_ctl;
	logic [AW-1:0]        wr_addr;
	logic [7:0]           wr_data;
	logic [AW-1:0]        rd_addr;
	logic [7:0]           rd_data;

	// frame state and sequencing
	mrfr_ctrl #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.data_byte    (data_byte),
		.read_index   (read_index),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.frame_event  (frame_event),
		.frame_held   (frame_held),
		.frame_length (frame_length),
		.read_data    (read_data),
		.store_ctl    (store_ctl),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data)
	);

	// frame byte memory
	mrfr_store #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_store (
		.clk       (clk),
		.store_ctl (store_ctl),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data)
	);

endmodule

// ===== hdl/mrfr_checker.sv =====
// port-level checker for the frame receiver and its bind to the top level
`timescale 1ns / 1ps
`include "modbus_rtu_frame_receiver_top_macros.svh"

module mrfr_checker #(
	parameter int BUFFER_DEPTH = mrfr_pkg::BUFFER_DEPTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] frame_event,
	input logic       frame_held,
	input logic [8:0] frame_length
);

	logic [11:0] result_bits;

	// status fields of the result channel in one vector
	assign result_bits = {frame_event, frame_held, frame_length};

	// every accepted transaction yields a result in the next cycle
	`MRFR_ASSERT_NXT(a_result_follows, in_valid && in_ready, out_valid)

	// a stalled result keeps its fields
	`MRFR_ASSERT_NXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(result_bits))

	// a good frame leaves the ready flag set
	`MRFR_ASSERT_IMP(a_good_sets_ready, out_valid && frame_event == mrfr_pkg::EV_GOOD, frame_held)

	// a crc failure empties the buffer
	`MRFR_ASSERT_IMP(a_fail_clears, out_valid && frame_event == mrfr_pkg::EV_CRC_FAIL, !frame_held && frame_length == 9'd0)

	// length never passes the buffer depth
	`MRFR_ASSERT_IMP(a_length_bound, out_valid, frame_length <= 9'(BUFFER_DEPTH))

endmodule

bind modbus_rtu_frame_receiver_top mrfr_checker #(
	.BUFFER_DEPTH(BUFFER_DEPTH)
) u_mrfr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.frame_event  (frame_event),
	.frame_held   (frame_held),
	.frame_length (frame_length)
);

// ===== tb/tb.sv =====
// testbench for the modbus rtu frame receiver: directed table, framed random traffic, self check
`timescale 1ns / 1ps

module tb;
	import mrfr_pkg::*;

	localparam int BUF_DEPTH = BUFFER_DEPTH_DEF;

	// one result of the receiver, as seen on its output channel
	typedef struct packed {
		logic [1:0] ev;
		logic       rdy;
		logic [8:0] len;
		logic [7:0] rd;
	} frame_status_t;

	// one row of the directed table; typed rows carry their own answer
	typedef struct {
		logic [1:0]    act;
		logic [7:0]    dat;
		logic [7:0]    idx;
		bit            typed;
		frame_status_t st;
	} probe_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = 16'd0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  action = ACT_TICK;
	logic [7:0]  data_byte = 8'd0;
	logic [7:0]  read_index = 8'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  frame_event;
	logic        frame_held;
	logic [8:0]  frame_length;
	logic [7:0]  read_data;

	// receiver state as the testbench tracks it
	logic [7:0]  model_store [BUF_DEPTH];
	bit          model_written [BUF_DEPTH];
	logic [8:0]  model_fill = '0;
	logic        model_ready = 1'b0;
	logic [15:0] model_silence = '0;
	logic [15:0] model_crc = CRC_INIT;
	logic [15:0] model_timeout = TIMEOUT_RESET;

	frame_status_t pending_status_q [$];
	probe_row_t    probe_table [$];

	bit calm = 1'b1;
	int item_count = 0;
	int result_count = 0;
	int good_frames = 0;
	int failed_frames = 0;
	int mismatch_count = 0;
	int mid_timeout;
	int last_timeout;

	modbus_rtu_frame_receiver_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.data_byte    (data_byte),
		.read_index   (read_index),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.frame_event  (frame_event),
		.frame_held   (frame_held),
		.frame_length (frame_length),
		.read_data    (read_data)
	);

	always #10 clk = ~clk;

	// reflected crc-16/modbus, folding one data bit per step
	function automatic logic [15:0] modbus_crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c = c >> 1;
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	function automatic void drop_model_frame();
		model_fill = '0;
		model_ready = 1'b0;
		model_crc = CRC_INIT;
	endfunction

	// advance the tracked receiver by one transaction and return its result
	function automatic frame_status_t advance_receiver(input logic [1:0] act,
			input logic [7:0] dat, input logic [7:0] idx);
		frame_status_t st;
		st = '0;
		case (act)
			ACT_BYTE: begin
				if (model_fill >= BUF_DEPTH) begin
					drop_model_frame();
				end else begin
					model_store[model_fill[7:0]] = dat;
					model_written[model_fill[7:0]] = 1'b1;
					model_fill = model_fill + 9'd1;
					model_crc = modbus_crc_fold(model_crc, dat);
					model_silence = '0;
				end
			end
			ACT_TICK: begin
				if (model_silence != SILENCE_MAX) begin
					model_silence = model_silence + 16'd1;
				end
				if (model_fill != 0 && !model_ready && model_silence >= model_timeout) begin
					if (model_fill >= MIN_FRAME_LEN && model_crc == 16'd0) begin
						model_ready = 1'b1;
						st.ev = EV_GOOD;
					end else begin
						drop_model_frame();
						st.ev = EV_CRC_FAIL;
					end
				end
			end
			ACT_CLEAR: begin
				drop_model_frame();
			end
			default: begin
				if (idx < BUF_DEPTH) begin
					st.rd = model_store[idx];
				end
			end
		endcase
		st.rdy = model_ready;
		st.len = model_fill;
		return st;
	endfunction

	function automatic probe_row_t probe(input logic [1:0] act, input logic [7:0] dat,
			input logic [7:0] idx, input bit typed, input logic [1:0] ev, input logic rdy,
			input logic [8:0] len, input logic [7:0] rd);
		probe_row_t r;
		r.act = act;
		r.dat = dat;
		r.idx = idx;
		r.typed = typed;
		r.st = {ev, rdy, len, rd};
		return r;
	endfunction

	// a stored entry that has been written, or -1 while there is none
	function automatic int pick_written_index();
		int start;
		start = $urandom_range(BUF_DEPTH - 1);
		for (int i = 0; i < BUF_DEPTH; i++) begin
			if (model_written[(start + i) % BUF_DEPTH]) begin
				return (start + i) % BUF_DEPTH;
			end
		end
		return -1;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		$display("mismatch at result %0d: %s got %0d, expected %0d", result_count, what, got,
			want);
	endtask

	// offer one transaction, wait for it to be taken, record what it must produce
	task automatic send_item(input logic [1:0] act, input logic [7:0] dat, input logic [7:0] idx,
			input bit typed, input frame_status_t typed_status);
		frame_status_t st;
		while (!calm && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		data_byte <= dat;
		read_index <= idx;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		st = advance_receiver(act, dat, idx);
		pending_status_q.push_back(typed ? typed_status : st);
		item_count++;
	endtask

	task automatic send_byte(input logic [7:0] dat);
		send_item(ACT_BYTE, dat, 8'($urandom_range(255)), 1'b0, '0);
	endtask

	task automatic send_tick();
		send_item(ACT_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0, '0);
	endtask

	task automatic send_clear();
		send_item(ACT_CLEAR, 8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0, '0);
	endtask

	task automatic send_read(input int idx);
		send_item(ACT_READ, 8'($urandom_range(255)), 8'(idx), 1'b0, '0);
	endtask

	task automatic send_read_any();
		int idx;
		idx = pick_written_index();
		if (idx >= 0) begin
			send_read(idx);
		end
	endtask

	// any action with random fields; reads only touch written entries
	task automatic send_noise();
		logic [1:0] act;
		int         idx;
		act = 2'($urandom_range(3));
		idx = pick_written_index();
		if (act == ACT_READ && idx < 0) begin
			act = ACT_TICK;
		end
		send_item(act, 8'($urandom_range(255)), 8'(idx < 0 ? 0 : idx), 1'b0, '0);
	endtask

	// frame of payload plus crc (low byte first), then silence up to the timeout
	// mode 0 sends a good frame, 1 one with a flipped bit, 2 a short run with no crc
	task automatic send_frame(input int payload_len, input int mode);
		logic [7:0]  frame_bytes [$];
		logic [15:0] crc;
		int          hit;
		crc = CRC_INIT;
		for (int i = 0; i < payload_len; i++) begin
			frame_bytes.push_back(8'($urandom_range(255)));
			crc = modbus_crc_fold(crc, frame_bytes[i]);
		end
		if (mode != 2) begin
			frame_bytes.push_back(crc[7:0]);
			frame_bytes.push_back(crc[15:8]);
		end
		if (mode == 1) begin
			hit = $urandom_range(frame_bytes.size() - 1);
			frame_bytes[hit] = frame_bytes[hit] ^ (8'd1 << $urandom_range(7));
		end
		foreach (frame_bytes[i]) begin
			send_byte(frame_bytes[i]);
			// inter-byte silence that stays short of the timeout
			if (model_timeout > 1 && $urandom_range(4) == 0) begin
				repeat ($urandom_range(1, model_timeout - 1)) send_tick();
			end
		end
		repeat (model_timeout == 0 ? 1 : model_timeout) send_tick();
		repeat ($urandom_range(0, 2)) send_tick();
	endtask

	// mostly well-formed frames, some corrupted or short, the rest noise
	task automatic run_random(input int n_items);
		int stop_at;
		int pick;
		stop_at = item_count + n_items;
		while (item_count < stop_at) begin
			if (model_ready && $urandom_range(9) < 7) begin
				send_clear();
			end
			pick = $urandom_range(99);
			if (pick < 55) begin
				send_frame($urandom_range(1, 10), 0);
			end else if (pick < 70) begin
				send_frame($urandom_range(1, 10), 1);
			end else if (pick < 78) begin
				send_frame($urandom_range(1, 2), 2);
			end else begin
				repeat ($urandom_range(1, 6)) send_noise();
			end
			if (pick < 78) begin
				repeat ($urandom_range(0, 2)) send_read_any();
				pick = $urandom_range(9);
				if (pick < 3) begin
					send_clear();
				end else if (pick < 5) begin
					send_byte(8'($urandom_range(255)));
				end
			end
		end
	endtask

	// let every result drain, then write the timeout register while idle
	task automatic set_timeout(input logic [15:0] value);
		in_valid <= 1'b0;
		while (pending_status_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (2) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		model_timeout = value;
	endtask

	// result side stalls at random except during calm stretches
	always @(posedge clk) begin
		out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 8);
	end

	// compare each result with the oldest expectation
	always @(posedge clk) begin
		frame_status_t want;
		if (arst_n && out_valid && out_ready) begin
			result_count++;
			if (frame_event == EV_GOOD) begin
				good_frames++;
			end
			if (frame_event == EV_CRC_FAIL) begin
				failed_frames++;
			end
			if (pending_status_q.size() == 0) begin
				report_mismatch("result with nothing pending", 1, 0);
			end else begin
				want = pending_status_q.pop_front();
				if (frame_event !== want.ev) begin
					report_mismatch("frame_event", frame_event, want.ev);
				end
				if (frame_held !== want.rdy) begin
					report_mismatch("frame_held", frame_held, want.rdy);
				end
				if (frame_length !== want.len) begin
					report_mismatch("frame_length", frame_length, want.len);
				end
				if (read_data !== want.rd) begin
					report_mismatch("read_data", read_data, want.rd);
				end
			end
		end
	end

	// run limit
	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		// directed frame 01 03 00 00 00 01 with crc 84 0a, checked at the reset timeout of 5
		probe_table.push_back(probe(ACT_TICK, 8'h00, 8'h00, 1, EV_NONE, 0, 9'd0, 8'h00));
		probe_table.push_back(probe(ACT_BYTE, 8'h01, 8'h00, 0, EV_NONE, 0, 9'd0, 8'h00));
		probe_table.push_back(probe(ACT_BYTE, 8'h03, 8'h00, 0, EV_NONE, 0, 9'd0, 8'h00));
		probe_table.push_back(probe(ACT_BYTE, 8'h00, 8'h00, 0, EV_NONE, 0, 9'd0, 8'h00));
		probe_table.push_back(probe(ACT_BYTE, 8'h00, 8'h00, 0, EV_NONE, 0, 9'd0, 8'h00));
		probe_table.push_back(probe(ACT_BYTE, 8'h00, 8'h00, 0, EV_NONE, 0, 9'd0, 8'h00));
		probe_table.push_back(probe(ACT_BYTE, 8'h01, 8'h00, 0, EV_NONE, 0, 9'd0, 8'h00));
		probe_table.push_back(probe(ACT_BYTE, 8'h84, 8'h00, 0, EV_NONE, 0, 9'd0, 8'h00));
		probe_table.push_back(probe(ACT_BYTE, 8'h0A, 8'h00, 0, EV_NONE, 0, 9'd0, 8'h00));
		probe_table.push_back(probe(ACT_TICK, 8'h00, 8'h00, 0, EV_NONE, 0, 9'd0, 8'h00));
		probe_table.push_back(probe(ACT_TICK, 8'h00, 8'h00, 0, EV_NONE, 0, 9'd0, 8'h00));
		probe_table.push_back(probe(ACT_TICK, 8'h00, 8'h00, 0, EV_NONE, 0, 9'd0, 8'h00));
		probe_table.push_back(probe(ACT_TICK, 8'h00, 8'h00, 0, EV_NONE, 0, 9'd0, 8'h00));
		probe_table.push_back(probe(ACT_TICK, 8'h00, 8'h00, 1, EV_GOOD, 1, 9'd8, 8'h00));
		probe_table.push_back(probe(ACT_READ, 8'h00, 8'h00, 1, EV_NONE, 1, 9'd8, 8'h01));
		probe_table.push_back(probe(ACT_READ, 8'h00, 8'h07, 1, EV_NONE, 1, 9'd8, 8'h0A));
		// a byte while a frame is ready is appended to it
		probe_table.push_back(probe(ACT_BYTE, 8'hFF, 8'h00, 0, EV_NONE, 0, 9'd0, 8'h00));
		probe_table.push_back(probe(ACT_CLEAR, 8'h00, 8'h00, 1, EV_NONE, 0, 9'd0, 8'h00));
		// short frame of two bytes, stale entry read, then the failing check
		probe_table.push_back(probe(ACT_BYTE, 8'h00, 8'h00, 0, EV_NONE, 0, 9'd0, 8'h00));
		probe_table.push_back(probe(ACT_BYTE, 8'hFF, 8'h00, 0, EV_NONE, 0, 9'd0, 8'h00));
		probe_table.push_back(probe(ACT_READ, 8'h00, 8'h08, 1, EV_NONE, 0, 9'd2, 8'hFF));
		probe_table.push_back(probe(ACT_TICK, 8'h00, 8'h00, 0, EV_NONE, 0, 9'd0, 8'h00));
		probe_table.push_back(probe(ACT_TICK, 8'h00, 8'h00, 0, EV_NONE, 0, 9'd0, 8'h00));
		probe_table.push_back(probe(ACT_TICK, 8'h00, 8'h00, 0, EV_NONE, 0, 9'd0, 8'h00));
		probe_table.push_back(probe(ACT_TICK, 8'h00, 8'h00, 0, EV_NONE, 0, 9'd0, 8'h00));
		probe_table.push_back(probe(ACT_TICK, 8'h00, 8'h00, 1, EV_CRC_FAIL, 0, 9'd0, 8'h00));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at the reset timeout
		foreach (probe_table[i]) begin
			send_item(probe_table[i].act, probe_table[i].dat, probe_table[i].idx,
				probe_table[i].typed, probe_table[i].st);
		end

		// timeout of one, then zero; at either one every tick ends the frame
		calm = 1'b0;
		set_timeout(16'd1);
		run_random(130);
		set_timeout(16'd0);
		run_random(70);

		// full buffer: a 256-byte good frame, then overflow while ready and while not
		calm = 1'b1;
		set_timeout(16'd3);
		send_clear();
		send_frame(BUF_DEPTH - 2, 0);
		send_read(0);
		send_read(BUF_DEPTH - 1);
		send_byte(8'($urandom_range(255)));
		repeat (BUF_DEPTH) send_byte(8'($urandom_range(255)));
		send_byte(8'($urandom_range(255)));
		repeat (3) send_tick();
		repeat (8) send_read($urandom_range(BUF_DEPTH - 1));

		// mid-range timeout, first half with no idling on either side
		mid_timeout = $urandom_range(2, 9);
		set_timeout(16'(mid_timeout));
		run_random(90);
		calm = 1'b0;
		run_random(90);

		// highest timeout: a few ticks after a frame never end it
		set_timeout(16'hFFFF);
		send_clear();
		repeat (6) send_byte(8'($urandom_range(255)));
		repeat (3) send_tick();
		send_clear();

		last_timeout = $urandom_range(1, 6);
		set_timeout(16'(last_timeout));
		run_random(130);

		in_valid <= 1'b0;
		while (pending_status_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);

		$display("%0d transactions, %0d results checked, %0d good frames, %0d crc failures",
			item_count, result_count, good_frames, failed_frames);
		$display("timeouts 5, 1, 0, 3, %0d, 65535 and %0d; buffer filled to 256 and overrun",
			mid_timeout, last_timeout);
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
